/* rtl/hem_pkg.sv */
// Package for the HDR exposure merge block: widths, function codes and the
// item structure that passes from the front end to the back end. No dependencies.
package hem_pkg;
    localparam int LevelBits  = 12;
    localparam int Levels     = 1 << LevelBits;
    localparam int AccBits    = 60;
    localparam int QExtra     = 18;
    localparam int QueueDepth = 2;

    typedef enum logic [1:0] {
        FUNC_RESP   = 2'd0,
        FUNC_WEIGHT = 2'd1,
        FUNC_SAMPLE = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef struct packed {
        logic [LevelBits-1:0] lvl_r;
        logic [LevelBits-1:0] lvl_g;
        logic [LevelBits-1:0] lvl_b;
        logic [19:0]          coef;
        logic                 last;
    } sample_t;
endpackage

/* rtl/hdr_exposure_merge.sv */
// HDR exposure merge, top level: links the front end to the back end.
// Depends on hem_pkg, hem_front and hem_back.
//
// Usage: items enter through a queue-style port (push/full). Func 0 and 1
// write the response and weight tables; func 2 carries one frame
// sample of a pixel, func 3 is dropped. Tables must be written before use.
// A table write is held off with full high until the sample queue is empty
// and the back end is idle, so earlier samples still see the old tables.
// Samples wait in a two-entry queue; the back end takes a sample and then
// handles each channel through a RAM read, two multiplier stages and an
// accumulate step, the channels one by one. On a sample marked last, each
// channel in turn is divided by an iterative divider at one quotient bit
// per cycle, and the three results go together to the output register.
// The result is held in an output register and shown while empty is low;
// a pop transfers it. If the receiver stalls, the back end waits with the
// next result and the sample queue then fills and raises full.
// Reset clears the sums and queues; table contents are undefined until written.
module hdr_exposure_merge
    import hem_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  func,
    input  logic [1:0]  channel,
    input  logic [11:0] table_index,
    input  logic [15:0] table_value,
    input  logic [11:0] red_level,
    input  logic [11:0] green_level,
    input  logic [11:0] blue_level,
    input  logic [19:0] frame_coef,
    input  logic        last_frame,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] red_radiance,
    output logic [31:0] green_radiance,
    output logic [31:0] blue_radiance
);
    logic                 q_valid, q_take;
    logic                 back_idle;
    sample_t              q_item;
    logic [1:0]           rd_sel;
    logic [LevelBits-1:0] rd_level;
    logic [15:0]          rd_resp, rd_weight;

    hem_front u_front (.clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .func(func), .channel(channel), .table_index(table_index),
        .table_value(table_value), .red_level(red_level), .green_level(green_level),
        .blue_level(blue_level), .frame_coef(frame_coef), .last_frame(last_frame),
        .q_valid(q_valid), .q_item(q_item), .q_take(q_take), .back_idle(back_idle),
        .rd_sel(rd_sel), .rd_level(rd_level), .rd_resp(rd_resp), .rd_weight(rd_weight));

    hem_back u_back (.clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item),
        .q_take(q_take), .idle(back_idle), .rd_sel(rd_sel), .rd_level(rd_level),
        .rd_resp(rd_resp), .rd_weight(rd_weight), .empty(empty), .pop(pop),
        .red_radiance(red_radiance), .green_radiance(green_radiance),
        .blue_radiance(blue_radiance));
endmodule

/* rtl/hem_ram.sv */
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module hem_ram #(
    parameter int Width = 16,
    parameter int Depth = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* rtl/hem_front.sv */
// Front end: accepts items, performs table writes and queues sample items.
// Depends on hem_pkg and hem_ram.
module hem_front
    import hem_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [1:0]           func,
    input  logic [1:0]           channel,
    input  logic [11:0]          table_index,
    input  logic [15:0]          table_value,
    input  logic [11:0]          red_level,
    input  logic [11:0]          green_level,
    input  logic [11:0]          blue_level,
    input  logic [19:0]          frame_coef,
    input  logic                 last_frame,
    output logic                 q_valid,
    output sample_t              q_item,
    input  logic                 q_take,
    input  logic                 back_idle,
    input  logic [1:0]           rd_sel,
    input  logic [LevelBits-1:0] rd_level,
    output logic [15:0]          rd_resp,
    output logic [15:0]          rd_weight
);
    sample_t     fifo_reg [QueueDepth];
    logic [1:0]  cnt_reg, cnt_next;
    logic        wp_reg, rp_reg;
    logic        acc, is_sample, is_table;
    logic [LevelBits-1:0] idx;
    logic        we_r, we_g, we_b, we_w;

    // A table write waits until every sample accepted before it has read the tables.
    assign is_table  = (func_t'(func) == FUNC_RESP) || (func_t'(func) == FUNC_WEIGHT);
    assign full      = (cnt_reg == 2'(QueueDepth))
                       || (is_table && ((cnt_reg != 2'd0) || !back_idle));
    assign acc       = push && !full;
    assign idx       = table_index[LevelBits-1:0];
    assign is_sample = acc && (func_t'(func) == FUNC_SAMPLE);
    assign we_r      = acc && (func_t'(func) == FUNC_RESP) && (channel == 2'd0);
    assign we_g      = acc && (func_t'(func) == FUNC_RESP) && (channel == 2'd1);
    assign we_b      = acc && (func_t'(func) == FUNC_RESP) && (channel == 2'd2);
    assign we_w      = acc && (func_t'(func) == FUNC_WEIGHT);

    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = fifo_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg + 2'(is_sample) - 2'(q_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (is_sample)
            begin
                wp_reg <= ~wp_reg;
            end
            if (q_take)
            begin
                rp_reg <= ~rp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_sample)
        begin
            fifo_reg[wp_reg] <= '{lvl_r: red_level[LevelBits-1:0],
                                  lvl_g: green_level[LevelBits-1:0],
                                  lvl_b: blue_level[LevelBits-1:0],
                                  coef: frame_coef, last: last_frame};
        end
    end

    // One response RAM per channel; the back end reads one channel at a time.
    logic [15:0] rd_r, rd_g, rd_b;
    logic [1:0]  sel_reg;

    hem_ram #(.Width(16), .Depth(Levels)) u_resp_r (.clk(clk), .we(we_r), .waddr(idx),
        .wdata(table_value), .raddr(rd_level), .rdata(rd_r));
    hem_ram #(.Width(16), .Depth(Levels)) u_resp_g (.clk(clk), .we(we_g), .waddr(idx),
        .wdata(table_value), .raddr(rd_level), .rdata(rd_g));
    hem_ram #(.Width(16), .Depth(Levels)) u_resp_b (.clk(clk), .we(we_b), .waddr(idx),
        .wdata(table_value), .raddr(rd_level), .rdata(rd_b));
    hem_ram #(.Width(16), .Depth(Levels)) u_weight (.clk(clk), .we(we_w), .waddr(idx),
        .wdata(table_value), .raddr(rd_level), .rdata(rd_weight));

    always_ff @(posedge clk)
    begin
        sel_reg <= rd_sel;
    end

    always_comb
    begin
        case (sel_reg)
            2'd0:    rd_resp = rd_r;
            2'd1:    rd_resp = rd_g;
            default: rd_resp = rd_b;
        endcase
    end
endmodule

/* rtl/hem_div.sv */
// Iterative restoring divider: floor(num * 2^18 / den) saturated to 32 bits,
// one quotient bit per cycle. Depends on hem_pkg.
module hem_div
    import hem_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [AccBits-1:0] num,
    input  logic [AccBits-1:0] den,
    output logic               done,
    output logic [31:0]        quo
);
    // Quotient of num*2^18/den can need 78 bits; at 2^32 and above it saturates.
    localparam int QBits = AccBits + QExtra;
    localparam int CntBits = $clog2(QBits + 1);

    logic [QBits-1:0]   n_reg;
    logic [AccBits:0]   r_reg;
    logic [AccBits-1:0] d_reg;
    logic [32:0]        q_reg;
    logic               sat_reg;
    logic [CntBits-1:0] cnt_reg;
    logic               busy_reg;
    logic [AccBits:0]   r_sh, r_sub;
    logic               ge;

    assign r_sh  = {r_reg[AccBits-1:0], n_reg[QBits-1]};
    assign ge    = (r_sh >= {1'b0, d_reg});
    assign r_sub = ge ? (r_sh - {1'b0, d_reg}) : r_sh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CntBits'(QBits);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CntBits'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= {num, {QExtra{1'b0}}};
            d_reg   <= den;
            r_reg   <= '0;
            q_reg   <= '0;
            sat_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            n_reg   <= {n_reg[QBits-2:0], 1'b0};
            r_reg   <= r_sub;
            q_reg   <= {q_reg[31:0], ge};
            // A one about to move past bit 31 means the quotient needs 33 bits.
            sat_reg <= sat_reg | q_reg[31] | q_reg[32];
        end
    end

    always_comb
    begin
        if (d_reg == '0)
        begin
            quo = '0;
        end
        else if (sat_reg || q_reg[32])
        begin
            quo = '1;
        end
        else
        begin
            quo = q_reg[31:0];
        end
    end
endmodule

/* rtl/hem_back.sv */
// Back end: reads the tables, accumulates per channel, divides on the last
// frame and holds the result in an output register. Depends on hem_pkg, hem_div.
module hem_back
    import hem_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  sample_t              q_item,
    output logic                 q_take,
    output logic                 idle,
    output logic [1:0]           rd_sel,
    output logic [LevelBits-1:0] rd_level,
    input  logic [15:0]          rd_resp,
    input  logic [15:0]          rd_weight,
    output logic                 empty,
    input  logic                 pop,
    output logic [31:0]          red_radiance,
    output logic [31:0]          green_radiance,
    output logic [31:0]          blue_radiance
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_READ = 8'b0000_0010,
        S_MUL1 = 8'b0000_0100,
        S_MUL2 = 8'b0000_1000,
        S_ACC  = 8'b0001_0000,
        S_DIV  = 8'b0010_0000,
        S_WAIT = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    state_t      st_reg;
    logic [1:0]  ch_reg;
    sample_t     it_reg;
    logic [35:0] wc_reg;
    logic [15:0] resp_reg;
    logic [51:0] nt_reg;
    logic [55:0] dt_reg;
    logic [AccBits-1:0] num_reg [3];
    logic [AccBits-1:0] den_reg [3];
    logic [31:0] res_reg [3];
    logic        out_full_reg;
    logic        div_start, div_done;
    logic [31:0] div_quo;
    logic [AccBits:0] nsum, dsum;
    logic        load_out;

    assign q_take   = (st_reg == S_IDLE) && q_valid;
    assign idle     = (st_reg == S_IDLE);
    assign rd_sel   = ch_reg;
    assign load_out = (st_reg == S_OUT) && (!out_full_reg || pop);

    always_comb
    begin
        case (ch_reg)
            2'd0:    rd_level = it_reg.lvl_r;
            2'd1:    rd_level = it_reg.lvl_g;
            default: rd_level = it_reg.lvl_b;
        endcase
    end

    assign nsum = {1'b0, num_reg[ch_reg]} + (AccBits+1)'(nt_reg);
    assign dsum = {1'b0, den_reg[ch_reg]} + (AccBits+1)'(dt_reg);
    assign div_start = (st_reg == S_DIV);

    hem_div u_div (.clk(clk), .rst_n(rst_n), .start(div_start),
        .num(num_reg[ch_reg]), .den(den_reg[ch_reg]), .done(div_done), .quo(div_quo));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= S_IDLE;
            ch_reg       <= '0;
            out_full_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                num_reg[i] <= '0;
                den_reg[i] <= '0;
            end
        end
        else
        begin
            // A new result may enter the result register in the cycle its old content is popped.
            if (load_out)
            begin
                out_full_reg <= 1'b1;
            end
            else if (pop && out_full_reg)
            begin
                out_full_reg <= 1'b0;
            end
            case (st_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        ch_reg <= '0;
                        st_reg <= S_READ;
                    end
                end
                S_READ: st_reg <= S_MUL1;
                S_MUL1: st_reg <= S_MUL2;
                S_MUL2: st_reg <= S_ACC;
                S_ACC:
                begin
                    num_reg[ch_reg] <= nsum[AccBits] ? '1 : nsum[AccBits-1:0];
                    den_reg[ch_reg] <= dsum[AccBits] ? '1 : dsum[AccBits-1:0];
                    if (ch_reg == 2'd2)
                    begin
                        ch_reg <= '0;
                        st_reg <= it_reg.last ? S_DIV : S_IDLE;
                    end
                    else
                    begin
                        ch_reg <= ch_reg + 2'd1;
                        st_reg <= S_READ;
                    end
                end
                S_DIV: st_reg <= S_WAIT;
                S_WAIT:
                begin
                    if (div_done)
                    begin
                        num_reg[ch_reg] <= '0;
                        den_reg[ch_reg] <= '0;
                        if (ch_reg == 2'd2)
                        begin
                            st_reg <= S_OUT;
                        end
                        else
                        begin
                            ch_reg <= ch_reg + 2'd1;
                            st_reg <= S_DIV;
                        end
                    end
                end
                S_OUT:
                begin
                    if (load_out)
                    begin
                        ch_reg <= '0;
                        st_reg <= S_IDLE;
                    end
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    logic [31:0] stage_reg [3];

    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            it_reg <= q_item;
        end
        if (st_reg == S_MUL1)
        begin
            wc_reg   <= rd_weight * it_reg.coef;
            resp_reg <= rd_resp;
        end
        if (st_reg == S_MUL2)
        begin
            nt_reg <= resp_reg * wc_reg;
            dt_reg <= wc_reg * it_reg.coef;
        end
        if (st_reg == S_WAIT && div_done)
        begin
            stage_reg[ch_reg] <= div_quo;
        end
        if (load_out)
        begin
            res_reg[0] <= stage_reg[0];
            res_reg[1] <= stage_reg[1];
            res_reg[2] <= stage_reg[2];
        end
    end

    assign empty          = !out_full_reg;
    assign red_radiance   = res_reg[0];
    assign green_radiance = res_reg[1];
    assign blue_radiance  = res_reg[2];
endmodule

/* rtl/hem_checker.sv */
// Port-level checker for the HDR exposure merge block, bound to the top level.
// Depends on hdr_exposure_merge.
module hem_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [31:0] red_radiance,
    input logic [31:0] green_radiance,
    input logic [31:0] blue_radiance
);
    // A waiting result holds until it is transferred.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(red_radiance)
            && $stable(green_radiance) && $stable(blue_radiance))
        else $error("result changed before transfer");

    // Handshake signals are always driven once reset is over.
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({push, pop, empty, full}))
        else $error("handshake signal unknown");

    // Sanity check on empty: it can only fall after being high.
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(empty) |-> $past(empty))
        else $error("empty fell without being set");

    a_rst: assert property (@(posedge clk) !rst_n |=> empty && !full)
        else $error("flags wrong in reset");
endmodule

bind hdr_exposure_merge hem_checker u_hem_checker (.clk(clk), .rst_n(rst_n),
    .push(push), .full(full), .empty(empty), .pop(pop),
    .red_radiance(red_radiance), .green_radiance(green_radiance),
    .blue_radiance(blue_radiance));
